@@ hw/rtl/mrc_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response checker. No dependencies; imported by every module of the block.
package mrc_pkg;

	localparam int unsigned MAX_FRAME_DEF = 16;
	localparam int unsigned MIN_LEN       = 5;
	localparam int unsigned Q_DEPTH       = 4;
	localparam int unsigned Q_PTR_W       = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W       = $clog2(Q_DEPTH + 1);
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 8;
	localparam int unsigned LEN_W         = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int unsigned EXC_BIT  = 7;

	localparam logic [7:0] RST_SLAVE_ID   = 8'd1;
	localparam logic [6:0] RST_FUNCTION   = 7'd4;
	localparam logic [7:0] RST_BYTE_COUNT = 8'd2;
	localparam logic [7:0] WIDE_COUNT     = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLAVE_ID   = 2'd0,
		CFG_FUNCTION   = 2'd1,
		CFG_BYTE_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_CRC    = 3'd2,
		ST_ID     = 3'd3,
		ST_EXC    = 3'd4,
		ST_FUNC   = 3'd5,
		ST_BCOUNT = 3'd6
	} status_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_EOF  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} mrc_in_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] reg_value;
		logic [7:0]  exception_code;
		logic [4:0]  frame_length;
	} mrc_out_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} mrc_cmd_t;

	typedef struct packed {
		logic [7:0] slave_id;
		logic [6:0] function_code;
		logic [7:0] byte_count;
	} mrc_cfg_t;

	// reflected CRC-16, one byte folded in, bit by bit
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/mrc_front.sv @@
// Front end: accepts byte / end-of-frame items, drops bytes past the frame
// capacity and pushes the rest into the command queue. Uses mrc_pkg.
module mrc_front #(
	parameter int unsigned MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mrc_pkg::mrc_in_t  item,
	output logic              push,
	output mrc_pkg::mrc_cmd_t push_cmd,
	input  logic              q_full
);
	import mrc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             room;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign room       = count_q < CNT_W'(MAX_FRAME);

	// overflow bytes never reach the queue
	assign push          = accept && (item.op || room);
	assign push_cmd.kind = item.op ? CMD_EOF : CMD_BYTE;
	assign push_cmd.data = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.op) begin
				count_q <= '0;
			end else if (room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_front_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME))
		else $error("front byte count exceeds frame capacity");
`endif

endmodule

@@ hw/rtl/mrc_queue.sv @@
// Small show-ahead command queue between front and back end.
// Depth from mrc_pkg::Q_DEPTH.
module mrc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrc_pkg::mrc_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output mrc_pkg::mrc_cmd_t pop_cmd,
	output logic              empty
);
	import mrc_pkg::*;

	mrc_cmd_t             slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full    = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && push) |-> pop)
		else $error("push into full command queue");
`endif

endmodule

@@ hw/rtl/mrc_back.sv @@
// Back end: folds stored bytes into the CRC and frame fields, evaluates the
// frame checks on end of frame and holds the result register. Uses mrc_pkg.
module mrc_back #(
	parameter int unsigned MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrc_pkg::mrc_cfg_t cfg,
	input  logic              q_empty,
	input  mrc_pkg::mrc_cmd_t cmd,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output mrc_pkg::mrc_out_t result
);
	import mrc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       slave_q;
	logic [7:0]       func_q;
	logic [7:0]       third_q;
	logic [31:0]      value_q;
	logic             res_valid_q;
	mrc_out_t         res_q;
	mrc_out_t         res_next;
	logic [15:0]      crc_next;
	logic             out_free;

	assign out_free     = !res_valid_q || result_ready;
	assign pop          = !q_empty && (cmd.kind == CMD_BYTE || out_free);
	assign crc_next     = crc16_byte(crc_q, cmd.data);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		res_next.reg_value      = '0;
		res_next.exception_code = '0;
		res_next.frame_length   = LEN_W'(cnt_q);
		if (cnt_q < CNT_W'(MIN_LEN)) begin
			res_next.status = ST_SHORT;
		end else if (crc_q != 16'h0000) begin
			res_next.status = ST_CRC;
		end else if (slave_q != cfg.slave_id) begin
			res_next.status = ST_ID;
		end else if (func_q[EXC_BIT]) begin
			res_next.status         = ST_EXC;
			res_next.exception_code = third_q;
		end else if (func_q != {1'b0, cfg.function_code}) begin
			res_next.status = ST_FUNC;
		end else if (third_q != cfg.byte_count) begin
			res_next.status = ST_BCOUNT;
		end else begin
			res_next.status = ST_OK;
			if (cfg.byte_count == WIDE_COUNT) begin
				res_next.reg_value = value_q;
			end else begin
				res_next.reg_value = {16'h0000, value_q[31:16]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			cnt_q       <= '0;
			slave_q     <= '0;
			func_q      <= '0;
			third_q     <= '0;
			value_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				if (cmd.kind == CMD_BYTE) begin
					crc_q <= crc_next;
					cnt_q <= cnt_q + CNT_W'(1);
					case (cnt_q)
						CNT_W'(0): slave_q         <= cmd.data;
						CNT_W'(1): func_q          <= cmd.data;
						CNT_W'(2): third_q         <= cmd.data;
						CNT_W'(3): value_q[31:24]  <= cmd.data;
						CNT_W'(4): value_q[23:16]  <= cmd.data;
						CNT_W'(5): value_q[15:8]   <= cmd.data;
						CNT_W'(6): value_q[7:0]    <= cmd.data;
						default: ;
					endcase
				end else begin
					res_valid_q <= 1'b1;
					res_q       <= res_next;
					crc_q       <= CRC_INIT;
					cnt_q       <= '0;
					slave_q     <= '0;
					func_q      <= '0;
					third_q     <= '0;
					value_q     <= '0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_back_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME))
		else $error("stored byte count exceeds frame capacity");

	a_back_clear_on_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.kind == CMD_EOF) |=> (cnt_q == '0 && crc_q == CRC_INIT && value_q == '0))
		else $error("frame state not cleared after end of frame");

	a_back_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.kind == CMD_EOF) |=> res_valid_q)
		else $error("end of frame did not produce a result");
`endif

endmodule

@@ hw/rtl/modbus_rtu_response_checker.sv @@
// Modbus RTU response checker, top level: configuration registers and the
// front end / queue / back end. Depends on mrc_pkg, mrc_front, mrc_queue, mrc_back.
//
// Usage:
//   item channel (item_valid/item_ready/item): op = 0 carries one received
//   byte, op = 1 marks end of frame (bus silence or timeout). Bytes beyond
//   MAX_FRAME in one frame are dropped.
//   result channel (result_valid/result_ready/result): one transaction per end
//   of frame with status, register value, exception code and frame length.
//   cfg_we/cfg_index/cfg_data: register writes, taken at the clock edge with
//   cfg_we high; write only while no frame is in flight.
// Timing:
//   One item per cycle while the queue is not full. An accepted end of frame
//   is written into the queue, popped once it is at the head and the result
//   register is free, and that pop loads the result register and raises result_valid.
//   When result_ready is low the result is held; data bytes keep draining,
//   a following end of frame waits in the queue, and item_ready drops once
//   the four-entry queue is full.
// Reset: clears queue, frame state (CRC to 0xFFFF) and the result register;
//   configuration returns to slave id 1, function 4, byte count 2.
module modbus_rtu_response_checker #(
	parameter int unsigned MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  mrc_pkg::mrc_in_t                  item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mrc_pkg::mrc_out_t                 result,
	input  logic                              cfg_we,
	input  logic [mrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mrc_pkg::*;

	mrc_cfg_t cfg_q;
	logic     push;
	mrc_cmd_t push_cmd;
	logic     q_full;
	logic     q_empty;
	logic     pop;
	mrc_cmd_t pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_id      <= RST_SLAVE_ID;
			cfg_q.function_code <= RST_FUNCTION;
			cfg_q.byte_count    <= RST_BYTE_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ID:   cfg_q.slave_id      <= cfg_data;
				CFG_FUNCTION:   cfg_q.function_code <= cfg_data[6:0];
				CFG_BYTE_COUNT: cfg_q.byte_count    <= cfg_data;
				default: ;
			endcase
		end
	end

	mrc_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	mrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	mrc_back #(
		.MAX_FRAME(MAX_FRAME)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.cmd          (pop_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
